### hdl/vfbf_pkg.sv
// ----------------------------------------------------------------------------
// vfbf_pkg
// Shared types and constants for the frame bitrate feedback block.
// ----------------------------------------------------------------------------
package vfbf_pkg;

  localparam int RATE_W   = 20;
  localparam int BITS_W   = 24;
  localparam int GAIN_W   = 16;
  localparam int VAR_W    = 16;
  localparam int ERR_W    = 15;  // smoothed error kept offset by +1.0 (Q4.12 + 4096)
  localparam int MUL_A_W  = 20;
  localparam int MUL_B_W  = 31;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_R_W  = 24;  // remainder / divisor width
  localparam int DIV_Q_W  = 20;  // quotient bits, also width of the shifted-in field
  localparam int DIV_C_W  = 5;   // step counter

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_READY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN_LO  = 16'd8192;
  localparam logic [GAIN_W-1:0] GAIN_HI  = 16'd32768;
  localparam logic [ERR_W-1:0]  ERR_ZERO = 15'd4096;
  localparam logic [ERR_W-1:0]  ERR_MAX  = 15'd32767;
  localparam logic [RATE_W-1:0] RATE_MAX = 20'hFFFFF;
  localparam logic [31:0]       FACTOR_ONE = 32'h1000_0000;
  // ceil(2^22 / 5): x/10 = (x * RECIP_5) >> 23, x/20 = ((x >> 2) * RECIP_5) >> 22,
  // exact for dividends below 2^22
  localparam logic [MUL_A_W-1:0] RECIP_5 = 20'd838861;

  typedef struct packed {
    logic               start;
    logic [DIV_R_W-1:0] rem0;     // initial remainder, must be below divisor
    logic [DIV_Q_W-1:0] low;      // dividend bits shifted in, MSB first
    logic [DIV_C_W-1:0] steps;
    logic [DIV_R_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               ovf;      // quotient would not fit in the step count
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

### hdl/video_frame_bitrate_feedback.sv
// ----------------------------------------------------------------------------
// video_frame_bitrate_feedback
// Per-frame bitrate feedback: target requests and frame reports.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | in        | in_valid / in_stall   | cmd, base_rate_kbps,
//          |           |                       | used_bits, goal_bits
//  out     | out       | out_valid / out_stall | target_rate_kbps, ok, gain_now
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A request makes three passes through the shared multiplier. A report runs
//  two serial divisions (15 and 20 quotient bits) and two reciprocal
//  multiplies for the divides by 10 and 20. A report with zero used bits
//  skips the second division and its multiply; failed requests and ignored
//  reports go straight to the output state.
//  in_stall is high while a transaction is in work; a finished result sits in
//  the output register, so the next input is taken while it waits.
//  No clearing pass after reset; config writes are taken every cycle.
// ----------------------------------------------------------------------------
module video_frame_bitrate_feedback
  import vfbf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [RATE_W-1:0]     base_rate_kbps,
  input  logic [BITS_W-1:0]     used_bits,
  input  logic [BITS_W-1:0]     goal_bits,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RATE_W-1:0]     target_rate_kbps,
  output logic                  ok,
  output logic [GAIN_W-1:0]     gain_now,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_REQ_A  = 4'd1;
  localparam logic [3:0] S_REQ_B  = 4'd2;
  localparam logic [3:0] S_REQ_C  = 4'd3;
  localparam logic [3:0] S_REQ_D  = 4'd4;
  localparam logic [3:0] S_REQ_E  = 4'd5;
  localparam logic [3:0] S_RPT_E  = 4'd6;
  localparam logic [3:0] S_RPT_EW = 4'd7;
  localparam logic [3:0] S_RPT_S  = 4'd8;
  localparam logic [3:0] S_RPT_SW = 4'd9;
  localparam logic [3:0] S_RPT_I  = 4'd10;
  localparam logic [3:0] S_RPT_IW = 4'd11;
  localparam logic [3:0] S_RPT_G  = 4'd12;
  localparam logic [3:0] S_RPT_GW = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0]        state;

  // configuration
  logic              ready_cfg;
  logic [RATE_W-1:0] min_rate;
  logic [RATE_W-1:0] max_rate;
  logic [VAR_W-1:0]  var_gain;

  // loop state
  logic [GAIN_W-1:0] gain;
  logic [ERR_W-1:0]  err_ofs;   // smoothed error + 1.0

  // captured transaction
  logic [RATE_W-1:0] base_r;
  logic [BITS_W-1:0] act_r;
  logic [BITS_W-1:0] tgt_r;
  logic [RATE_W-1:0] t_r;
  logic [MUL_B_W-1:0] factor_r;
  logic [RATE_W-1:0] rate_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_acc;
  logic               out_free;
  logic [RATE_W+1:0]  t_raw;
  logic [RATE_W-1:0]  t_hi;
  logic [RATE_W-1:0]  t_cl;
  logic [31:0]        factor_sum;
  logic [22:0]        r_raw;
  logic [RATE_W-1:0]  r_sat;
  logic [ERR_W-1:0]   err_plus;
  logic [18:0]        err_sum;
  logic [ERR_W-1:0]   err_q;
  logic [20:0]        gain_sum;
  logic [16:0]        g_q;
  logic [GAIN_W-1:0]  g_cl;

  vfbf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  vfbf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // request datapath
  assign t_raw      = prod[RATE_W+15:14];
  assign t_hi       = (t_raw > {2'b00, max_rate}) ? max_rate : t_raw[RATE_W-1:0];
  assign t_cl       = (t_hi < min_rate) ? min_rate : t_hi;
  // 1.0 + variance * error, with error stored offset by +1.0
  assign factor_sum = FACTOR_ONE - {4'b0, var_gain, 12'b0} + {1'b0, prod[MUL_B_W-1:0]};
  assign r_raw      = prod[50:28];
  assign r_sat      = (|r_raw[22:20]) ? RATE_MAX : r_raw[RATE_W-1:0];

  // report datapath
  assign err_plus = div_rsp.ovf ? ERR_MAX : div_rsp.quot[ERR_W-1:0];
  assign err_sum  = {1'b0, err_ofs, 3'b000} + {4'b0, err_ofs} + {4'b0, err_plus};
  assign err_q    = prod[37:23];
  assign gain_sum = {1'b0, gain, 4'b0} + {4'b0, gain, 1'b0} + {5'b0, gain}
                  + {1'b0, div_rsp.quot};
  assign g_q      = prod[38:22];
  assign g_cl     = (g_q > {1'b0, GAIN_HI}) ? GAIN_HI :
                    (g_q < {1'b0, GAIN_LO}) ? GAIN_LO : g_q[GAIN_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_REQ_A: begin
        mul_a = base_r;
        mul_b = {15'b0, gain};
      end
      S_REQ_B: begin
        mul_a = {5'b0, err_ofs};
        mul_b = {15'b0, var_gain};
      end
      S_REQ_D: begin
        mul_a = t_r;
        mul_b = factor_r;
      end
      S_RPT_S: begin
        // (9 * err + e) / 10
        mul_a = RECIP_5;
        mul_b = {12'b0, err_sum};
      end
      S_RPT_G: begin
        // (19 * gain + inv) / 20
        mul_a = RECIP_5;
        mul_b = {12'b0, gain_sum[20:2]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_RPT_E: begin
        // (actual << 12) / target, 15 quotient bits
        div_req.start   = 1'b1;
        div_req.rem0    = {3'b0, act_r[BITS_W-1:3]};
        div_req.low     = {act_r[2:0], 17'b0};
        div_req.steps   = 5'd15;
        div_req.divisor = tgt_r;
      end
      S_RPT_I: begin
        // (target << 14) / actual, 20 quotient bits
        div_req.start   = 1'b1;
        div_req.rem0    = {6'b0, tgt_r[BITS_W-1:6]};
        div_req.low     = {tgt_r[5:0], 14'b0};
        div_req.steps   = 5'd20;
        div_req.divisor = act_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_cfg <= 1'b0;
      min_rate  <= '0;
      max_rate  <= RATE_MAX;
      var_gain  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_READY:    ready_cfg <= cfg_data[0];
        CFG_MIN_RATE: min_rate  <= cfg_data;
        CFG_MAX_RATE: max_rate  <= cfg_data;
        CFG_VARIANCE: var_gain  <= cfg_data[VAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gain      <= GAIN_ONE;
      err_ofs   <= ERR_ZERO;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!ready_cfg) begin
              state <= S_OUT;
            end else if (!cmd) begin
              state <= S_REQ_A;
            end else if (goal_bits == '0) begin
              state <= S_OUT;
            end else begin
              state <= S_RPT_E;
            end
          end
        end
        S_REQ_A:  state <= S_REQ_B;
        S_REQ_B:  state <= S_REQ_C;
        S_REQ_C:  state <= S_REQ_D;
        S_REQ_D:  state <= S_REQ_E;
        S_REQ_E:  state <= S_OUT;
        S_RPT_E:  state <= S_RPT_EW;
        S_RPT_EW: begin
          if (div_rsp.done) begin
            state <= S_RPT_S;
          end
        end
        S_RPT_S:  state <= S_RPT_SW;
        S_RPT_SW: begin
          err_ofs <= err_q;
          if (act_r == '0) begin
            gain  <= GAIN_HI;
            state <= S_OUT;
          end else begin
            state <= S_RPT_I;
          end
        end
        S_RPT_I:  state <= S_RPT_IW;
        S_RPT_IW: begin
          if (div_rsp.done) begin
            state <= S_RPT_G;
          end
        end
        S_RPT_G: begin
          // inverse too large: gain saturates high
          if (div_rsp.ovf) begin
            gain  <= GAIN_HI;
            state <= S_OUT;
          end else begin
            state <= S_RPT_GW;
          end
        end
        S_RPT_GW: begin
          gain  <= g_cl;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r <= base_rate_kbps;
      act_r  <= used_bits;
      tgt_r  <= goal_bits;
      rate_r <= '0;
    end
    if (state == S_REQ_B) begin
      t_r <= t_cl;
    end
    if (state == S_REQ_C) begin
      factor_r <= factor_sum[MUL_B_W-1:0];
    end
    if (state == S_REQ_E) begin
      rate_r <= r_sat;
    end
    if (state == S_OUT && out_free) begin
      target_rate_kbps <= rate_r;
      ok               <= ready_cfg;
      gain_now         <= gain;
    end
  end

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain >= GAIN_LO && gain <= GAIN_HI)
    else $error("rate gain out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input taken while a transaction is in work");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> target_rate_kbps == '0)
    else $error("failed transaction carries a nonzero rate");

endmodule

### hdl/vfbf_mul.sv
// ----------------------------------------------------------------------------
// vfbf_mul
// Shared unsigned multiplier, product registered.
// ----------------------------------------------------------------------------
module vfbf_mul
  import vfbf_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

### hdl/vfbf_div.sv
// ----------------------------------------------------------------------------
// vfbf_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vfbf_div
  import vfbf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_R_W-1:0] rem;
  logic [DIV_R_W-1:0] divr;
  logic [DIV_Q_W-1:0] low;
  logic [DIV_Q_W-1:0] quot;
  logic [DIV_C_W-1:0] cnt;
  logic               run;
  logic               done;
  logic               ovf;
  logic [DIV_R_W:0]   trial;

  assign trial = {rem, low[DIV_Q_W-1]} - {1'b0, divr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        // quotient needs more bits than requested: flag and skip the loop
        if (req.rem0 >= req.divisor) begin
          ovf  <= 1'b1;
          done <= 1'b1;
          run  <= 1'b0;
        end else begin
          ovf  <= 1'b0;
          run  <= 1'b1;
        end
      end else if (run) begin
        if (cnt == DIV_C_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem0;
      low  <= req.low;
      cnt  <= req.steps;
      divr <= req.divisor;
      quot <= '0;
    end else if (run) begin
      if (!trial[DIV_R_W]) begin
        rem <= trial[DIV_R_W-1:0];
      end else begin
        rem <= {rem[DIV_R_W-2:0], low[DIV_Q_W-1]};
      end
      quot <= {quot[DIV_Q_W-2:0], ~trial[DIV_R_W]};
      low  <= {low[DIV_Q_W-2:0], 1'b0};
      cnt  <= cnt - DIV_C_W'(1);
    end
  end

  assign rsp.busy = run;
  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quot = quot;

endmodule
